// ===== rtl/o3des_pkg.sv =====
// Shared constants for the exact 3D orientation sign pipeline.
`default_nettype none

package o3des_pkg;

  // Width of each coordinate field on the ports, and the default coordinate width.
  localparam int FIELD_BITS     = 32;
  localparam int COORD_BITS_DEF = 32;

  // Coordinate order on the input side: p, q, r, s, each x, y, z.
  localparam int NUM_COORDS = 12;
  localparam int CRD_PX = 0;
  localparam int CRD_PY = 1;
  localparam int CRD_PZ = 2;
  localparam int CRD_QX = 3;
  localparam int CRD_QY = 4;
  localparam int CRD_QZ = 5;
  localparam int CRD_RX = 6;
  localparam int CRD_RY = 7;
  localparam int CRD_RZ = 8;
  localparam int CRD_SX = 9;
  localparam int CRD_SY = 10;
  localparam int CRD_SZ = 11;

  // Differences a = q - p, b = r - p, c = s - p.
  localparam int NUM_DIFFS = 9;
  localparam int DF_AX = 0;
  localparam int DF_AY = 1;
  localparam int DF_AZ = 2;
  localparam int DF_BX = 3;
  localparam int DF_BY = 4;
  localparam int DF_BZ = 5;
  localparam int DF_CX = 6;
  localparam int DF_CY = 7;
  localparam int DF_CZ = 8;

  // Axes of the c vector carried alongside the minors.
  localparam int NUM_AXES = 3;
  localparam int AXIS_X   = 0;
  localparam int AXIS_Y   = 1;
  localparam int AXIS_Z   = 2;

  // The three 2x2 minors of the a and b rows.
  localparam int NUM_MINORS = 3;
  localparam int MN_01 = 0;
  localparam int MN_02 = 1;
  localparam int MN_12 = 2;

  // Orientation codes (two's complement in two bits).
  localparam logic [1:0] ORIENT_ZERO = 2'b00;
  localparam logic [1:0] ORIENT_POS  = 2'b01;
  localparam logic [1:0] ORIENT_BAD  = 2'b10;
  localparam logic [1:0] ORIENT_NEG  = 2'b11;

endpackage

`default_nettype wire

// ===== rtl/o3des_diff.sv =====
// First pipeline stage: coordinate extraction and differences against p.
`default_nettype none

module o3des_diff
  import o3des_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [FIELD_BITS-1:0]        field [NUM_COORDS],
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [COORD_BITS:0]   diff [NUM_DIFFS]
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  logic signed [CB-1:0] crd [NUM_COORDS];
  logic signed [DW-1:0] diff_nxt [NUM_DIFFS];
  logic signed [DW-1:0] diff_r   [NUM_DIFFS];
  logic                 valid_r;

  // Each coordinate is the low COORD_BITS bits of its field, or the whole
  // field zero-extended when the coordinate is wider than the field.
  generate
    if (COORD_BITS < FIELD_BITS) begin : g_narrow
      for (genvar i = 0; i < NUM_COORDS; i++) begin : g_crd
        assign crd[i] = field[i][CB-1:0];
      end
    end else begin : g_wide
      for (genvar i = 0; i < NUM_COORDS; i++) begin : g_crd
        assign crd[i] = CB'(field[i]);
      end
    end
  endgenerate

  // Differences are one bit wider than the coordinates and never overflow.
  always_comb begin
    diff_nxt[DF_AX] = DW'(crd[CRD_QX]) - DW'(crd[CRD_PX]);
    diff_nxt[DF_AY] = DW'(crd[CRD_QY]) - DW'(crd[CRD_PY]);
    diff_nxt[DF_AZ] = DW'(crd[CRD_QZ]) - DW'(crd[CRD_PZ]);
    diff_nxt[DF_BX] = DW'(crd[CRD_RX]) - DW'(crd[CRD_PX]);
    diff_nxt[DF_BY] = DW'(crd[CRD_RY]) - DW'(crd[CRD_PY]);
    diff_nxt[DF_BZ] = DW'(crd[CRD_RZ]) - DW'(crd[CRD_PZ]);
    diff_nxt[DF_CX] = DW'(crd[CRD_SX]) - DW'(crd[CRD_PX]);
    diff_nxt[DF_CY] = DW'(crd[CRD_SY]) - DW'(crd[CRD_PY]);
    diff_nxt[DF_CZ] = DW'(crd[CRD_SZ]) - DW'(crd[CRD_PZ]);
  end

  // The stage takes a new transaction when empty or when its contents move on.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      diff_r <= diff_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign diff     = diff_r;

endmodule

`default_nettype wire

// ===== rtl/o3des_minor.sv =====
// Second and third pipeline stages: 2x2 products and the three minors.
`default_nettype none

module o3des_minor
  import o3des_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [COORD_BITS:0]       diff [NUM_DIFFS],
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [2*COORD_BITS+2:0]   minor [NUM_MINORS],
  output logic signed [COORD_BITS:0]       cvec [NUM_AXES]
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int MW = PW + 1;
  localparam int NUM_PRODS = 2 * NUM_MINORS;

  // Product slots: the two products of each minor sit side by side.
  localparam int PR_AXBY = 0;
  localparam int PR_AYBX = 1;
  localparam int PR_AXBZ = 2;
  localparam int PR_AZBX = 3;
  localparam int PR_AYBZ = 4;
  localparam int PR_AZBY = 5;

  logic signed [PW-1:0] prod_nxt  [NUM_PRODS];
  logic signed [PW-1:0] prod_r    [NUM_PRODS];
  logic signed [DW-1:0] c1_nxt    [NUM_AXES];
  logic signed [DW-1:0] c1_r      [NUM_AXES];
  logic                 valid1_r;
  logic                 ready1;

  logic signed [MW-1:0] minor_nxt [NUM_MINORS];
  logic signed [MW-1:0] minor_r   [NUM_MINORS];
  logic signed [DW-1:0] c2_r      [NUM_AXES];
  logic                 valid2_r;
  logic                 ready2;

  // Stage one: six signed products, one multiplier each.
  always_comb begin
    prod_nxt[PR_AXBY] = diff[DF_AX] * diff[DF_BY];
    prod_nxt[PR_AYBX] = diff[DF_AY] * diff[DF_BX];
    prod_nxt[PR_AXBZ] = diff[DF_AX] * diff[DF_BZ];
    prod_nxt[PR_AZBX] = diff[DF_AZ] * diff[DF_BX];
    prod_nxt[PR_AYBZ] = diff[DF_AY] * diff[DF_BZ];
    prod_nxt[PR_AZBY] = diff[DF_AZ] * diff[DF_BY];
    c1_nxt[AXIS_X]    = diff[DF_CX];
    c1_nxt[AXIS_Y]    = diff[DF_CY];
    c1_nxt[AXIS_Z]    = diff[DF_CZ];
  end

  // Stage two: each minor is the difference of its pair of products.
  always_comb begin
    minor_nxt[MN_01] = MW'(prod_r[PR_AXBY]) - MW'(prod_r[PR_AYBX]);
    minor_nxt[MN_02] = MW'(prod_r[PR_AXBZ]) - MW'(prod_r[PR_AZBX]);
    minor_nxt[MN_12] = MW'(prod_r[PR_AYBZ]) - MW'(prod_r[PR_AZBY]);
  end

  // Ready runs back through the stages; a full stage holds while blocked.
  assign ready2   = !valid2_r || dn_ready;
  assign ready1   = !valid1_r || ready2;
  assign up_ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_r <= up_valid;
      end
      if (ready2) begin
        valid2_r <= valid1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && ready1) begin
      prod_r <= prod_nxt;
      c1_r   <= c1_nxt;
    end
    if (valid1_r && ready2) begin
      minor_r <= minor_nxt;
      c2_r    <= c1_r;
    end
  end

  assign dn_valid = valid2_r;
  assign minor    = minor_r;
  assign cvec     = c2_r;

endmodule

`default_nettype wire

// ===== rtl/o3des_term.sv =====
// Fourth and fifth pipeline stages: minor times c, split into two partial products.
`default_nettype none

module o3des_term
  import o3des_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [2*COORD_BITS+2:0]   minor [NUM_MINORS],
  input  logic signed [COORD_BITS:0]       cvec [NUM_AXES],
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [3*COORD_BITS+3:0]   term [NUM_MINORS]
);

  localparam int DW  = COORD_BITS + 1;
  localparam int MW  = 2 * DW + 1;
  // Low part of a minor is unsigned, the high part signed and DW bits wide.
  localparam int LW  = DW + 1;
  localparam int HPW = 2 * DW;
  localparam int LPW = 2 * DW + 2;
  localparam int TW  = MW + DW;

  logic signed [DW-1:0]  cm       [NUM_MINORS];
  logic signed [HPW-1:0] ph_nxt   [NUM_MINORS];
  logic signed [HPW-1:0] ph_r     [NUM_MINORS];
  logic signed [LPW-1:0] pl_nxt   [NUM_MINORS];
  logic signed [LPW-1:0] pl_r     [NUM_MINORS];
  logic                  valid1_r;
  logic                  ready1;

  logic signed [TW-1:0]  term_nxt [NUM_MINORS];
  logic signed [TW-1:0]  term_r   [NUM_MINORS];
  logic                  valid2_r;
  logic                  ready2;

  // Pair each minor with the c component it multiplies in the expansion.
  always_comb begin
    cm[MN_01] = cvec[AXIS_Z];
    cm[MN_02] = cvec[AXIS_Y];
    cm[MN_12] = cvec[AXIS_X];
  end

  // Stage one: high and low partial products of each minor.
  always_comb begin
    for (int k = 0; k < NUM_MINORS; k++) begin
      ph_nxt[k] = $signed(minor[k][MW-1:LW]) * cm[k];
      pl_nxt[k] = $signed({1'b0, minor[k][LW-1:0]}) * cm[k];
    end
  end

  // Stage two: recombine the partial products into the full term.
  always_comb begin
    for (int k = 0; k < NUM_MINORS; k++) begin
      term_nxt[k] = (TW'(ph_r[k]) <<< LW) + TW'(pl_r[k]);
    end
  end

  assign ready2   = !valid2_r || dn_ready;
  assign ready1   = !valid1_r || ready2;
  assign up_ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_r <= up_valid;
      end
      if (ready2) begin
        valid2_r <= valid1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && ready1) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (valid1_r && ready2) begin
      term_r <= term_nxt;
    end
  end

  assign dn_valid = valid2_r;
  assign term     = term_r;

endmodule

`default_nettype wire

// ===== rtl/o3des_sign.sv =====
// Sixth and seventh pipeline stages: determinant sum and sign, with the output register.
`default_nettype none

module o3des_sign
  import o3des_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [3*COORD_BITS+3:0]   term [NUM_MINORS],
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic [1:0]                       orientation
);

  localparam int TW  = 3 * (COORD_BITS + 1) + 1;
  localparam int DTW = TW + 2;

  logic signed [DTW-1:0] det_nxt;
  logic signed [DTW-1:0] det_r;
  logic                  valid1_r;
  logic                  ready1;

  logic [1:0]            orient_nxt;
  logic [1:0]            orient_r;
  logic                  valid2_r;
  logic                  ready2;

  // Stage one: det = m01*cz - m02*cy + m12*cx, exact at full width.
  assign det_nxt = DTW'(term[MN_01]) - DTW'(term[MN_02]) + DTW'(term[MN_12]);

  // Stage two: sign from the top bit, zero from a reduction over the word.
  always_comb begin
    if (det_r[DTW-1]) begin
      orient_nxt = ORIENT_NEG;
    end else if (det_r == '0) begin
      orient_nxt = ORIENT_ZERO;
    end else begin
      orient_nxt = ORIENT_POS;
    end
  end

  assign ready2   = !valid2_r || dn_ready;
  assign ready1   = !valid1_r || ready2;
  assign up_ready = ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      if (ready1) begin
        valid1_r <= up_valid;
      end
      if (ready2) begin
        valid2_r <= valid1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && ready1) begin
      det_r <= det_nxt;
    end
    if (valid1_r && ready2) begin
      orient_r <= orient_nxt;
    end
  end

  assign dn_valid    = valid2_r;
  assign orientation = orient_r;

endmodule

`default_nettype wire

// ===== rtl/orientation_3d_exact_sign_unit.sv =====
// The pipeline has 7 register stages; an input transaction passes through all of them
// before its result is shown on out_valid.
// Throughput: one transaction per cycle while out_ready stays high; every stage is one
// register with its own valid bit, and the widest multiplier between registers is
// (DW+2) x DW bits. Back-pressure travels stage by stage, so empty stages still fill
// during a stall. Reset clears only the valid bits; data registers are not reset.
`default_nettype none

module orientation_3d_exact_sign_unit
  import o3des_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [FIELD_BITS-1:0] in_p_x,
  input  logic signed [FIELD_BITS-1:0] in_p_y,
  input  logic signed [FIELD_BITS-1:0] in_p_z,
  input  logic signed [FIELD_BITS-1:0] in_q_x,
  input  logic signed [FIELD_BITS-1:0] in_q_y,
  input  logic signed [FIELD_BITS-1:0] in_q_z,
  input  logic signed [FIELD_BITS-1:0] in_r_x,
  input  logic signed [FIELD_BITS-1:0] in_r_y,
  input  logic signed [FIELD_BITS-1:0] in_r_z,
  input  logic signed [FIELD_BITS-1:0] in_s_x,
  input  logic signed [FIELD_BITS-1:0] in_s_y,
  input  logic signed [FIELD_BITS-1:0] in_s_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [1:0]            out_orientation
);

  localparam int DW = COORD_BITS + 1;
  localparam int MW = 2 * DW + 1;
  localparam int TW = MW + DW;

  logic [FIELD_BITS-1:0] field [NUM_COORDS];
  logic signed [DW-1:0]  diff  [NUM_DIFFS];
  logic signed [MW-1:0]  minor [NUM_MINORS];
  logic signed [DW-1:0]  cvec  [NUM_AXES];
  logic signed [TW-1:0]  term  [NUM_MINORS];
  logic [1:0]            orient;

  logic diff_valid;
  logic diff_ready;
  logic minor_valid;
  logic minor_ready;
  logic term_valid;
  logic term_ready;

  // Gather the coordinate fields in p, q, r, s order.
  assign field[CRD_PX] = in_p_x;
  assign field[CRD_PY] = in_p_y;
  assign field[CRD_PZ] = in_p_z;
  assign field[CRD_QX] = in_q_x;
  assign field[CRD_QY] = in_q_y;
  assign field[CRD_QZ] = in_q_z;
  assign field[CRD_RX] = in_r_x;
  assign field[CRD_RY] = in_r_y;
  assign field[CRD_RZ] = in_r_z;
  assign field[CRD_SX] = in_s_x;
  assign field[CRD_SY] = in_s_y;
  assign field[CRD_SZ] = in_s_z;

  // Differences against p.
  o3des_diff #(
    .COORD_BITS (COORD_BITS)
  ) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .field    (field),
    .dn_valid (diff_valid),
    .dn_ready (diff_ready),
    .diff     (diff)
  );

  // Products and 2x2 minors.
  o3des_minor #(
    .COORD_BITS (COORD_BITS)
  ) u_minor (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (diff_valid),
    .up_ready (diff_ready),
    .diff     (diff),
    .dn_valid (minor_valid),
    .dn_ready (minor_ready),
    .minor    (minor),
    .cvec     (cvec)
  );

  // Minor times c component, as two partial products.
  o3des_term #(
    .COORD_BITS (COORD_BITS)
  ) u_term (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (minor_valid),
    .up_ready (minor_ready),
    .minor    (minor),
    .cvec     (cvec),
    .dn_valid (term_valid),
    .dn_ready (term_ready),
    .term     (term)
  );

  // Determinant sum and sign, ending in the output register.
  o3des_sign #(
    .COORD_BITS (COORD_BITS)
  ) u_sign (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (term_valid),
    .up_ready    (term_ready),
    .term        (term),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .orientation (orient)
  );

  assign out_orientation = $signed(orient);

  // No result may appear in the cycle after reset.
  a_reset_empties : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A ready output must let the whole pipeline advance, so the input is ready too.
  a_flow_through : assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipeline stalled while output is being taken");

  // The sign code never takes the unused pattern.
  a_orient_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (orient != ORIENT_BAD))
    else $error("invalid orientation code");

endmodule

`default_nettype wire
